>>> rtl/core/pvh_pkg.sv
// ============================================================================
// POLYVAL block hash package
// Shared types, codes and the GF(2^128) arithmetic used by the hash core.
// ============================================================================
package pvh_pkg;

    localparam int unsigned HALF_W = 64;
    localparam int unsigned FULL_W = 2 * HALF_W;

    // Configuration register indexes.
    typedef enum logic {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } reg_index_t;

    // Item actions.
    typedef enum logic {
        ACT_ABSORB = 1'b0,
        ACT_LOAD   = 1'b1
    } action_t;

    // Montgomery fold constant: x^127 + x^126 + x^121 terms of p(x) in the top byte.
    localparam logic [HALF_W-1:0] POLY_FOLD = 64'hc200_0000_0000_0000;

    // 64 x 64 -> 128 carry-less product.
    function automatic logic [FULL_W-1:0] clmul64(
        input logic [HALF_W-1:0] a,
        input logic [HALF_W-1:0] b
    );
        logic [FULL_W-1:0] prod;
        prod = '0;
        for (int i = 0; i < HALF_W; i++) begin
            if (b[i]) begin
                prod = prod ^ ({{HALF_W{1'b0}}, a} << i);
            end
        end
        return prod;
    endfunction

    // One fold: the low word times the constant is added into the swapped halves.
    function automatic logic [FULL_W-1:0] fold(input logic [FULL_W-1:0] w);
        logic [FULL_W-1:0] t;
        t = clmul64(w[HALF_W-1:0], POLY_FOLD);
        return {w[HALF_W-1:0] ^ t[FULL_W-1:HALF_W],
                w[FULL_W-1:HALF_W] ^ t[HALF_W-1:0]};
    endfunction

    // a * b * x^-128 mod p(x).
    function automatic logic [FULL_W-1:0] gf_dot(
        input logic [FULL_W-1:0] a,
        input logic [FULL_W-1:0] b
    );
        logic [FULL_W-1:0] lo;
        logic [FULL_W-1:0] hi;
        logic [FULL_W-1:0] p;
        logic [FULL_W-1:0] q;
        logic [HALF_W-1:0] mid_lo;
        logic [HALF_W-1:0] mid_hi;
        logic [FULL_W-1:0] red;
        lo     = clmul64(a[HALF_W-1:0], b[HALF_W-1:0]);
        hi     = clmul64(a[FULL_W-1:HALF_W], b[FULL_W-1:HALF_W]);
        p      = clmul64(a[HALF_W-1:0], b[FULL_W-1:HALF_W]);
        q      = clmul64(a[FULL_W-1:HALF_W], b[HALF_W-1:0]);
        mid_lo = lo[FULL_W-1:HALF_W] ^ p[HALF_W-1:0] ^ q[HALF_W-1:0];
        mid_hi = hi[HALF_W-1:0] ^ p[FULL_W-1:HALF_W] ^ q[FULL_W-1:HALF_W];
        red    = fold(fold({mid_lo, lo[HALF_W-1:0]}));
        return {red[FULL_W-1:HALF_W] ^ hi[FULL_W-1:HALF_W],
                red[HALF_W-1:0] ^ mid_hi};
    endfunction

endpackage

>>> rtl/core/pvh_data_if.sv
// ============================================================================
// POLYVAL data channel
// Valid/ready channel carrying one action and one 128-bit block per beat.
// ============================================================================
interface pvh_data_if
    import pvh_pkg::*;
();
    logic              valid;
    logic              ready;
    action_t           action;
    logic [HALF_W-1:0] block_low;
    logic [HALF_W-1:0] block_high;

    modport source (output valid, output action, output block_low, output block_high,
                    input ready);
    modport sink   (input valid, input action, input block_low, input block_high,
                    output ready);
endinterface

>>> rtl/core/pvh_result_if.sv
// ============================================================================
// POLYVAL result channel
// Valid/ready channel carrying the updated 128-bit accumulator per beat.
// ============================================================================
interface pvh_result_if
    import pvh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] acc_low;
    logic [HALF_W-1:0] acc_high;

    modport source (output valid, output acc_low, output acc_high, input ready);
    modport sink   (input valid, input acc_low, input acc_high, output ready);
endinterface

>>> rtl/core/polyval_block_hash_core.sv
// ============================================================================
// POLYVAL block hash core
// GF(2^128) universal hash accumulator with a combinational multiply stage.
// ============================================================================
//
// Usage: the hash key H is written as two 64-bit halves through the write
// port (index 0 low half, index 1 high half) while the core is idle. Each
// beat on the data channel carries an action and a 128-bit block. An absorb
// beat XORs the block into the accumulator and multiplies by H with the
// Montgomery reduction (acc * H * x^-128 mod p); a load beat writes the
// block straight into the accumulator. Every data beat gives exactly one
// result beat carrying the new accumulator.
//
// Pipeline and throughput: a data beat is captured in an input register;
// the whole multiply and reduction then runs between that register and
// the accumulator register, which also drives the result channel. The
// item moves on once the result register is free or emptying. One beat
// per cycle is sustained while the receiver takes every result. The rate
// is set by the feedback loop through the accumulator register.
//
// Reset clears the key, the accumulator and all valid flags. When the
// receiver stalls, the result is held and one further beat is still taken
// into the input register; ready then falls until the result is taken.
//
module polyval_block_hash_core
    import pvh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  reg_index_t        wr_index,
    input  logic [HALF_W-1:0] wr_data,
    pvh_data_if.sink          data,
    pvh_result_if.source      result
);

    // Key registers.
    logic [FULL_W-1:0] key_reg;

    // Input register stage.
    logic              in_valid_reg;
    action_t           in_action_reg;
    logic [FULL_W-1:0] in_block_reg;

    // Accumulator, which is also the result payload.
    logic              out_valid_reg;
    logic [FULL_W-1:0] acc_reg;
    logic [FULL_W-1:0] acc_next;

    logic              advance;

    // A held item advances whenever the result register is free or being emptied.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign data.ready = !in_valid_reg || advance;

    always_comb
    begin
        case (in_action_reg)
            ACT_LOAD:   acc_next = in_block_reg;
            ACT_ABSORB: acc_next = gf_dot(acc_reg ^ in_block_reg, key_reg);
            default:    acc_next = acc_reg;
        endcase
    end

    // Key writes; only legal while idle, so no interlock is needed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_KEY_LOW:  key_reg[HALF_W-1:0]      <= wr_data;
                REG_KEY_HIGH: key_reg[FULL_W-1:HALF_W] <= wr_data;
                default:      key_reg                  <= key_reg;
            endcase
        end
    end

    // Input register: control state is reset, the payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (data.ready)
        begin
            in_valid_reg <= data.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data.valid && data.ready)
        begin
            in_action_reg <= data.action;
            in_block_reg  <= {data.block_high, data.block_low};
        end
    end

    // Accumulator and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.acc_low  = acc_reg[HALF_W-1:0];
    assign result.acc_high = acc_reg[FULL_W-1:HALF_W];

    // The accumulator only moves when an item leaves the input register.
    a_acc_stable : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(acc_reg))
        else $error("accumulator changed without an item advancing");

    // A load beat places its block in the accumulator unchanged.
    a_load_value : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_action_reg == ACT_LOAD) |=> (acc_reg == $past(in_block_reg)))
        else $error("load beat did not set the accumulator");

    // Back-pressure only when both stages are full and the receiver stalls.
    a_ready_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !data.ready |-> (in_valid_reg && out_valid_reg && !result.ready))
        else $error("data channel stalled without cause");

    // Every advance presents a result beat in the next cycle.
    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item produced no result beat");

endmodule

>>> tb/tb_polyval_block_hash_core.sv
`timescale 1ns / 100ps
// ============================================================================
// POLYVAL block hash core testbench
// Drives absorb and load beats through the data channel under random sender
// gaps and receiver stalls, and predicts every accumulator beat with an
// independent bit-serial Montgomery multiply over GF(2^128).
// ============================================================================
module tb_polyval_block_hash_core;
    import pvh_pkg::*;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int unsigned IDLE_LIMIT    = 500;
    // Cycles allowed after the last result so a late extra beat would show.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned SEGMENTS      = 6;
    localparam int unsigned SEGMENT_BEATS = 110;

    // p(x) = x^128 + x^127 + x^126 + x^121 + 1, wide enough for a full product.
    localparam logic [2*FULL_W-1:0] FIELD_POLY = (256'd1 << 128) | (256'd1 << 127)
                                               | (256'd1 << 126) | (256'd1 << 121)
                                               | 256'd1;

    typedef struct packed {
        logic [HALF_W-1:0] acc_low;
        logic [HALF_W-1:0] acc_high;
    } acc_beat_t;

    logic              clk;
    logic              rst_n;
    logic              wr_en;
    reg_index_t        wr_index;
    logic [HALF_W-1:0] wr_data;

    pvh_data_if   data_ch ();
    pvh_result_if result_ch ();

    polyval_block_hash_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .data     (data_ch),
        .result   (result_ch)
    );

    // Our own copy of the key and the running accumulator.
    logic [FULL_W-1:0] hash_key;
    logic [FULL_W-1:0] hash_sum;

    // Accumulator values still owed by the core, oldest first.
    acc_beat_t pending_acc[$];

    bit gaps_on;
    bit stalls_on;

    int unsigned n_absorbed;
    int unsigned n_loaded;
    int unsigned n_checked;
    int unsigned n_key_writes;
    int unsigned n_errors;
    int unsigned idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // a * b * x^-128 mod p. The full carry-less product is formed first, then
    // one bit is divided out per step: whenever the lowest bit is set, p is
    // added to clear it, and the whole value is shifted down. After 128 steps
    // the degree is below 128, so the value is fully reduced.
    function automatic logic [FULL_W-1:0] polyval_product(
        input logic [FULL_W-1:0] a,
        input logic [FULL_W-1:0] b
    );
        logic [2*FULL_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < FULL_W; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ ({{FULL_W{1'b0}}, a} << i);
            end
        end
        for (int i = 0; i < FULL_W; i++)
        begin
            if (acc[0])
            begin
                acc = acc ^ FIELD_POLY;
            end
            acc = acc >> 1;
        end
        return acc[FULL_W-1:0];
    endfunction

    // Half-block values biased towards the corners: zero, all ones, a lone
    // set bit and a lone clear bit, otherwise fully random.
    function automatic logic [HALF_W-1:0] pick_half();
        logic [HALF_W-1:0] v;
        int unsigned       k;
        k = $urandom_range(0, HALF_W - 1);
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'd1 << k;
            3:       v = ~(64'd1 << k);
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    // One register write; the core is idle whenever this is called, so the
    // local key copy can change at once.
    task automatic write_key_reg(input reg_index_t idx, input logic [HALF_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        case (idx)
            REG_KEY_LOW:  hash_key[HALF_W-1:0]      = value;
            REG_KEY_HIGH: hash_key[FULL_W-1:HALF_W] = value;
        endcase
        n_key_writes++;
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Both halves, in a random order.
    task automatic set_key(input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi);
        if ($urandom_range(0, 1) == 0)
        begin
            write_key_reg(REG_KEY_LOW, lo);
            write_key_reg(REG_KEY_HIGH, hi);
        end
        else
        begin
            write_key_reg(REG_KEY_HIGH, hi);
            write_key_reg(REG_KEY_LOW, lo);
        end
    endtask

    // Offers one data beat after a random gap and, once it is taken, works
    // out the accumulator the core must return for it.
    task automatic send_block(
        input action_t           act,
        input logic [HALF_W-1:0] lo,
        input logic [HALF_W-1:0] hi
    );
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            data_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_ch.valid      <= 1'b1;
        data_ch.action     <= act;
        data_ch.block_low  <= lo;
        data_ch.block_high <= hi;
        do @(posedge clk); while (!data_ch.ready);
        if (act == ACT_LOAD)
        begin
            hash_sum = {hi, lo};
            n_loaded++;
        end
        else
        begin
            hash_sum = polyval_product(hash_sum ^ {hi, lo}, hash_key);
            n_absorbed++;
        end
        pending_acc.push_back('{acc_low: hash_sum[HALF_W-1:0],
                                acc_high: hash_sum[FULL_W-1:HALF_W]});
    endtask

    // Stops offering beats until every owed result has been taken, then
    // lets the pipeline settle so that the core is truly idle.
    task automatic wait_for_results();
        data_ch.valid <= 1'b0;
        while (pending_acc.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Straight after reset the key is zero, so any absorb gives zero, while a
    // load still returns its block unchanged.
    task automatic test_after_reset();
        send_block(ACT_ABSORB, '1, '1);
        send_block(ACT_LOAD, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_block(ACT_ABSORB, '0, '0);
        wait_for_results();
    endtask

    // Loads at the corners of the block range. Absorbing the loaded value
    // again cancels it, leaving a zero operand and hence a zero accumulator.
    task automatic test_load_corners();
        set_key(pick_half(), pick_half());
        send_block(ACT_LOAD, '0, '0);
        send_block(ACT_LOAD, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_block(ACT_LOAD, '1, '1);
        send_block(ACT_ABSORB, '1, '1);
        wait_for_results();
    endtask

    // Absorbs under keys at their extremes: all ones, the constant one and
    // the top bit alone.
    task automatic test_absorb_corners();
        set_key('1, '1);
        send_block(ACT_LOAD, '1, '1);
        send_block(ACT_ABSORB, '0, '0);
        send_block(ACT_ABSORB, '1, '1);
        wait_for_results();
        set_key(64'd1, '0);
        send_block(ACT_ABSORB, 64'd1, '0);
        send_block(ACT_ABSORB, '0, 64'h8000_0000_0000_0000);
        wait_for_results();
        set_key('0, 64'h8000_0000_0000_0000);
        send_block(ACT_ABSORB, '1, '1);
        send_block(ACT_ABSORB, 64'h8000_0000_0000_0000, 64'd1);
        wait_for_results();
    endtask

    // A zero key wipes out any accumulator: ordinary arithmetic, no fault.
    task automatic test_zero_key();
        set_key('0, '0);
        send_block(ACT_LOAD, pick_half(), pick_half());
        send_block(ACT_ABSORB, pick_half(), pick_half());
        wait_for_results();
    endtask

    // A partial hash is saved, the stream moves on, and the saved value is
    // loaded back before the same block is absorbed again.
    task automatic test_resume();
        logic [FULL_W-1:0] saved;
        logic [FULL_W-1:0] blk;
        set_key(pick_half(), pick_half());
        blk = {pick_half(), pick_half()};
        send_block(ACT_ABSORB, pick_half(), pick_half());
        saved = hash_sum;
        send_block(ACT_ABSORB, blk[HALF_W-1:0], blk[FULL_W-1:HALF_W]);
        send_block(ACT_ABSORB, pick_half(), pick_half());
        send_block(ACT_LOAD, saved[HALF_W-1:0], saved[FULL_W-1:HALF_W]);
        send_block(ACT_ABSORB, blk[HALF_W-1:0], blk[FULL_W-1:HALF_W]);
        wait_for_results();
    endtask

    // Long random streams, mostly absorbs with occasional loads, in segments
    // that each run under a fresh key. Idling on each side is switched on and
    // off every few dozen beats so that back-to-back stretches occur too.
    task automatic test_random_stream();
        logic [HALF_W-1:0] key_lo;
        logic [HALF_W-1:0] key_hi;
        action_t           act;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_for_results();
            case (seg)
                1:       begin key_lo = '1;    key_hi = '1;    end
                2:       begin key_lo = 64'd1; key_hi = '0;    end
                3:       begin key_lo = '0;    key_hi = 64'h8000_0000_0000_0000; end
                default: begin key_lo = {$urandom(), $urandom()};
                               key_hi = {$urandom(), $urandom()}; end
            endcase
            set_key(key_lo, key_hi);
            for (int i = 0; i < SEGMENT_BEATS; i++)
            begin
                if (i % 25 == 0)
                begin
                    gaps_on   = ($urandom_range(0, 3) != 0);
                    stalls_on = ($urandom_range(0, 3) != 0);
                end
                // Now and then the sender holds off until the core has
                // returned everything it owes.
                if ($urandom_range(0, 49) == 0)
                begin
                    wait_for_results();
                end
                act = ($urandom_range(0, 6) == 0) ? ACT_LOAD : ACT_ABSORB;
                send_block(act, pick_half(), pick_half());
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        wait_for_results();
    endtask

    // Result side: a random stall before each beat, then every beat taken is
    // compared with the oldest owed accumulator.
    initial
    begin : result_sink
        acc_beat_t   want;
        int unsigned stall;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = stalls_on ? $urandom_range(0, 3) : 0;
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            if (pending_acc.size() == 0)
            begin
                $error("result beat with no accumulator owed: acc_high %h acc_low %h",
                       result_ch.acc_high, result_ch.acc_low);
                n_errors++;
            end
            else
            begin
                want = pending_acc.pop_front();
                n_checked++;
                if (result_ch.acc_low !== want.acc_low)
                begin
                    $error("acc_low: expected %h, got %h", want.acc_low, result_ch.acc_low);
                    n_errors++;
                end
                if (result_ch.acc_high !== want.acc_high)
                begin
                    $error("acc_high: expected %h, got %h", want.acc_high, result_ch.acc_high);
                    n_errors++;
                end
            end
        end
    end

    // Hang detection: any cycle with a beat on either channel restarts the
    // count; a long enough silence means the core has stopped.
    always @(posedge clk)
    begin
        if ((data_ch.valid && data_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles.", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        wr_en              <= 1'b0;
        wr_index           <= REG_KEY_LOW;
        wr_data            <= '0;
        data_ch.valid      <= 1'b0;
        data_ch.action     <= ACT_ABSORB;
        data_ch.block_low  <= '0;
        data_ch.block_high <= '0;
        hash_key     = '0;
        hash_sum     = '0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        n_absorbed   = 0;
        n_loaded     = 0;
        n_checked    = 0;
        n_key_writes = 0;
        n_errors     = 0;
        idle_cycles  = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_load_corners();
        test_absorb_corners();
        test_zero_key();
        test_resume();
        test_random_stream();

        if (pending_acc.size() != 0)
        begin
            $error("%0d accumulator beats never arrived", pending_acc.size());
            n_errors++;
        end

        $display("Covered %0d absorbed and %0d loaded blocks across %0d key register writes.",
                 n_absorbed, n_loaded, n_key_writes);
        $display("Compared %0d result beats; %0d mismatches found.", n_checked, n_errors);
        if (n_errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
